### rtl/core/sadc_pkg.sv
package sadc_pkg;

   // Default build of the scanner
   localparam int NUM_CHANNELS_DEFAULT = 8;
   localparam int DATA_BITS_DEFAULT    = 12;

   // Fixed field widths
   localparam int CHAN_W   = 3;
   localparam int SAMPLE_W = 12;
   localparam int TICK_W   = 16;

   // Command frame: start, single-ended, three channel bits, sampling bit
   localparam int             CMD_BITS   = 6;
   localparam logic [1:0]     CMD_PREFIX = 2'b11;
   localparam logic [TICK_W-1:0] HALF_PERIOD_RESET = 16'd50;

   // Result of one tick, handed from the sequencer to the output register
   typedef struct packed {
      logic                sck_level;
      logic                chip_select_n;
      logic                mosi_level;
      logic                busy_res;
      logic                sample_valid;
      logic [CHAN_W-1:0]   sample_channel;
      logic [SAMPLE_W-1:0] sample_value;
      logic                scan_done;
      logic [SAMPLE_W-1:0] read_value;
   } sadc_result_type;

   // Command bit at frame position pos (MSB first), only for pos below CMD_BITS
   function automatic logic cmd_bit(input logic [CHAN_W-1:0] chan, input logic [2:0] pos);
      logic [CMD_BITS-1:0] word;
      logic                bit_val;
      word = {CMD_PREFIX, chan, 1'b0};
      case (pos)
         3'd0:    bit_val = word[5];
         3'd1:    bit_val = word[4];
         3'd2:    bit_val = word[3];
         3'd3:    bit_val = word[2];
         3'd4:    bit_val = word[1];
         3'd5:    bit_val = word[0];
         default: bit_val = 1'b0;
      endcase
      return bit_val;
   endfunction

endpackage

### rtl/core/sadc_core.sv
module sadc_core #(
   parameter int NUM_CHANNELS = sadc_pkg::NUM_CHANNELS_DEFAULT,
   parameter int DATA_BITS    = sadc_pkg::DATA_BITS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            step,
   input  logic                            start_scan,
   input  logic                            miso_level,
   input  logic [sadc_pkg::CHAN_W-1:0]     read_index,
   input  logic [sadc_pkg::TICK_W-1:0]     half_period_ticks,
   output sadc_pkg::sadc_result_type       result
);
   import sadc_pkg::*;

   localparam int READ_BITS  = DATA_BITS + 1;
   localparam int FRAME_BITS = CMD_BITS + READ_BITS;
   localparam int POS_W      = $clog2(FRAME_BITS + 1);
   localparam int EXT_W      = (DATA_BITS > SAMPLE_W) ? DATA_BITS : SAMPLE_W;
   localparam logic [POS_W-1:0]  FRAME_END = POS_W'(FRAME_BITS);
   localparam logic [POS_W-1:0]  CMD_END   = POS_W'(CMD_BITS);
   localparam logic [CHAN_W-1:0] LAST_CHAN = CHAN_W'(NUM_CHANNELS - 1);
   localparam int STORE_DEPTH = 1 << CHAN_W;

   logic [TICK_W-1:0]    tick_ff, tick_in;
   logic                 clock_high_ff, clock_high_in;
   logic [POS_W-1:0]     bit_pos_ff, bit_pos_in;
   logic [CHAN_W-1:0]    chan_ff, chan_in;
   logic [READ_BITS-1:0] shift_ff, shift_in;
   logic                 active_ff, active_in;
   logic                 select_n_ff, select_n_in;
   logic                 data_out_ff, data_out_in;
   logic [SAMPLE_W-1:0]  store_ff [STORE_DEPTH];

   logic [TICK_W-1:0]    half_period;
   logic [TICK_W-1:0]    tick_next;
   logic [POS_W-1:0]     bit_pos_next;
   logic [READ_BITS-1:0] shift_next;
   logic [EXT_W-1:0]     sample_ext;
   logic [SAMPLE_W-1:0]  sample;
   logic                 wr_en;
   logic                 done;

   // Zero half period acts as one tick
   assign half_period  = (half_period_ticks == '0) ? TICK_W'(1) : half_period_ticks;
   assign tick_next    = tick_ff + TICK_W'(1);
   assign bit_pos_next = bit_pos_ff + POS_W'(1);
   assign shift_next   = {shift_ff[READ_BITS-2:0], miso_level};
   // Drop the null bit, keep DATA_BITS, then fit to the 12-bit result
   assign sample_ext   = EXT_W'(shift_next[DATA_BITS-1:0]);
   assign sample       = sample_ext[SAMPLE_W-1:0];

   // Advance the bit sequencer by one tick
   always_comb begin
      tick_in       = tick_ff;
      clock_high_in = clock_high_ff;
      bit_pos_in    = bit_pos_ff;
      chan_in       = chan_ff;
      shift_in      = shift_ff;
      active_in     = active_ff;
      select_n_in   = select_n_ff;
      data_out_in   = data_out_ff;
      wr_en         = 1'b0;
      done          = 1'b0;
      if (step) begin
         if (!active_ff) begin
            if (start_scan) begin
               active_in     = 1'b1;
               chan_in       = '0;
               bit_pos_in    = '0;
               tick_in       = '0;
               clock_high_in = 1'b0;
               shift_in      = '0;
               select_n_in   = 1'b0;
               data_out_in   = cmd_bit('0, 3'd0);
            end
         end else begin
            tick_in = tick_next;
            if (tick_next >= half_period) begin
               tick_in = '0;
               if (bit_pos_ff >= FRAME_END) begin
                  // Deselect gap over: open the next channel's frame
                  chan_in       = chan_ff + CHAN_W'(1);
                  bit_pos_in    = '0;
                  shift_in      = '0;
                  clock_high_in = 1'b0;
                  select_n_in   = 1'b0;
                  data_out_in   = cmd_bit(chan_ff + CHAN_W'(1), 3'd0);
               end else if (!clock_high_ff) begin
                  clock_high_in = 1'b1;
               end else begin
                  if (bit_pos_ff >= CMD_END) begin
                     shift_in = shift_next;
                  end
                  bit_pos_in    = bit_pos_next;
                  clock_high_in = 1'b0;
                  if (bit_pos_next >= FRAME_END) begin
                     wr_en       = 1'b1;
                     select_n_in = 1'b1;
                     data_out_in = 1'b0;
                     if (chan_ff == LAST_CHAN) begin
                        active_in  = 1'b0;
                        done       = 1'b1;
                        bit_pos_in = '0;
                        chan_in    = '0;
                     end
                  end else if (bit_pos_next < CMD_END) begin
                     data_out_in = cmd_bit(chan_ff, bit_pos_next[2:0]);
                  end else begin
                     data_out_in = 1'b0;
                  end
               end
            end
         end
      end
   end

   // Hold sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff       <= '0;
         clock_high_ff <= 1'b0;
         bit_pos_ff    <= '0;
         chan_ff       <= '0;
         shift_ff      <= '0;
         active_ff     <= 1'b0;
         select_n_ff   <= 1'b1;
         data_out_ff   <= 1'b0;
      end else begin
         tick_ff       <= tick_in;
         clock_high_ff <= clock_high_in;
         bit_pos_ff    <= bit_pos_in;
         chan_ff       <= chan_in;
         shift_ff      <= shift_in;
         active_ff     <= active_in;
         select_n_ff   <= select_n_in;
         data_out_ff   <= data_out_in;
      end
   end

   // Store each finished sample in its channel's slot
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < STORE_DEPTH; i++) begin
            store_ff[i] <= '0;
         end
      end else if (wr_en) begin
         store_ff[chan_ff] <= sample;
      end
   end

   // Drive the tick's result, with the table read seeing this tick's write
   always_comb begin
      result.sck_level      = clock_high_in;
      result.chip_select_n  = select_n_in;
      result.mosi_level     = data_out_in;
      result.busy_res       = active_in;
      result.sample_valid   = wr_en;
      result.sample_channel = wr_en ? chan_ff : '0;
      result.sample_value   = wr_en ? sample : '0;
      result.scan_done      = done;
      result.read_value     = (wr_en && chan_ff == read_index) ? sample : store_ff[read_index];
   end

   // Idle pins: SCK low, chip select high, MOSI low
   a_idle_pins: assert property (@(posedge clock) disable iff (reset)
      !active_ff |-> (select_n_ff && !clock_high_ff && !data_out_ff))
      else $error("idle pins not parked");

   // Scan completion ends the scan on the next cycle
   a_done_ends_scan: assert property (@(posedge clock) disable iff (reset)
      done |=> !active_ff)
      else $error("scan still active after done");

   // Completion only comes with a stored sample
   a_done_with_sample: assert property (@(posedge clock) disable iff (reset)
      done |-> (wr_en && chan_ff == LAST_CHAN))
      else $error("scan done without last sample");

   // A sample is only taken at the end of a full frame with SCK high
   a_sample_at_frame_end: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (active_ff && clock_high_ff && bit_pos_next == FRAME_END))
      else $error("sample outside frame end");

endmodule

### rtl/core/spi_adc_channel_scanner_unit.sv
// SPI converter channel scanner.
// req channel: one request per system-clock tick, carrying the scan start flag,
//   the sampled MISO level and a result table index. Every request is one tick
//   of the serial timing, so a caller that wants real pin timing sends one each cycle.
// rsp channel: exactly one response per request, in order, with the pin levels
//   (SCK, chip select, MOSI), busy, any sample finished on that tick and the
//   table entry selected by the request's index.
// csr channel: writes the SCK half period in ticks; write it while no request
//   waits for its response. A new value ends the running half period as soon as
//   the tick count reaches it.
// Throughput is one request per cycle while the receiver keeps up; the response is
//   valid in the cycle after request accept, held in the single response register.
// When the receiver stalls, the response register holds and req_tready drops
//   until the held response is taken; the same cycle it is taken a new request
//   may enter.
// Reset: pins idle (SCK low, chip select high, MOSI low), no scan, result
//   table cleared, half period back to 50 ticks.
module spi_adc_channel_scanner_unit #(
   parameter int NUM_CHANNELS = sadc_pkg::NUM_CHANNELS_DEFAULT,
   parameter int DATA_BITS    = sadc_pkg::DATA_BITS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   // request: [0] start_scan, [1] miso_level, [4:2] read_index, [7:5] zero
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [7:0]                  req_tdata,
   // response: [0] sck_level, [1] chip_select_n, [2] mosi_level, [3] busy_res,
   // [4] sample_valid, [7:5] sample_channel, [19:8] sample_value,
   // [20] scan_done, [32:21] read_value, [39:33] zero
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [39:0]                 rsp_tdata,
   // half_period_ticks write
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [sadc_pkg::TICK_W-1:0] csr_data
);
   import sadc_pkg::*;

   logic              step;
   logic [TICK_W-1:0] half_period_ff;
   logic              rsp_valid_ff;
   logic [39:0]       rsp_data_ff;
   logic [39:0]       rsp_data_in;
   sadc_result_type   result;

   // Accept a request whenever the response register is free or being drained
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign step       = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // Hold the half period register
   always_ff @(posedge clock) begin
      if (reset) begin
         half_period_ff <= HALF_PERIOD_RESET;
      end else if (csr_valid && csr_ready) begin
         half_period_ff <= csr_data;
      end
   end

   sadc_core #(
      .NUM_CHANNELS (NUM_CHANNELS),
      .DATA_BITS    (DATA_BITS)
   ) u_core (
      .clock             (clock),
      .reset             (reset),
      .step              (step),
      .start_scan        (req_tdata[0]),
      .miso_level        (req_tdata[1]),
      .read_index        (req_tdata[4:2]),
      .half_period_ticks (half_period_ff),
      .result            (result)
   );

   // Pack the response, first field lowest
   assign rsp_data_in = {7'd0,
                         result.read_value,
                         result.scan_done,
                         result.sample_value,
                         result.sample_channel,
                         result.sample_valid,
                         result.busy_res,
                         result.mosi_level,
                         result.chip_select_n,
                         result.sck_level};

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Every accepted request leaves a response waiting
   a_req_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      step |=> rsp_valid_ff)
      else $error("request accepted without response");

   // A stalled response is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |-> !step)
      else $error("request accepted over a stalled response");

   // A response disappears only after being taken
   a_rsp_drains: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !step && rsp_tready) |=> !rsp_valid_ff)
      else $error("response not drained");

endmodule
